// File: rtl/tam_pkg.sv
package tam_pkg;

   localparam int WINDOW_LEN  = 16;
   localparam int SAMPLE_BITS = 24;

   localparam int SLOT_BITS     = $clog2(WINDOW_LEN);
   localparam int COUNT_BITS    = $clog2(WINDOW_LEN + 1);
   localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_LEN);
   localparam int EXT_BITS      = SUM_BITS - SAMPLE_BITS;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

   // per-axis ring and running-sum control
   typedef struct packed {
      logic capture;  // latch the incoming sample
      logic update;   // retire the oldest entry, write the new one, update the sum
      logic full;     // window is full: the entry at the slot holds a real sample
   } axis_ctrl_type;

   // bit-serial divider control
   typedef struct packed {
      logic load;     // take the sum magnitude and sign
      logic step;     // produce one quotient bit
   } div_ctrl_type;

endpackage

// File: rtl/three_axis_moving_average.sv
// One beat at a time: req_ready is high only in IDLE, so no new request beat is
//   taken until the means of the last one have gone to the output register. The
//   bit-serial divider (one quotient bit per cycle, SUM_BITS steps) is the bulk of it.
// Reset: synchronous, active high; clears sums, slot, fill count and handshake
//   state at once. The rings need no clearing pass: the fill count masks
//   entries not yet written to zero.
module three_axis_moving_average (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tam_pkg::SAMPLE_BITS-1:0] req_sample_x,
   input  logic signed [tam_pkg::SAMPLE_BITS-1:0] req_sample_y,
   input  logic signed [tam_pkg::SAMPLE_BITS-1:0] req_sample_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tam_pkg::SAMPLE_BITS-1:0] rsp_mean_x,
   output logic signed [tam_pkg::SAMPLE_BITS-1:0] rsp_mean_y,
   output logic signed [tam_pkg::SAMPLE_BITS-1:0] rsp_mean_z,
   output logic                                   rsp_warmed_up
);

   // IDLE:   wait for a request beat, capture it
   // UPDATE: retire the oldest entry, store the new sample, update sums
   // LOAD:   hand the sums to the dividers
   // DIVIDE: one quotient bit per cycle
   // DONE:   move the means into the output register once it is free
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [tam_pkg::SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [tam_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [tam_pkg::DIV_STEP_BITS-1:0] step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic signed [tam_pkg::SAMPLE_BITS-1:0] mean_x_ff, mean_y_ff, mean_z_ff;
   logic                                   warm_ff;

   logic                                   accept;
   logic                                   full;
   logic                                   out_load;
   tam_pkg::axis_ctrl_type                 axis_ctrl;
   tam_pkg::div_ctrl_type                  div_ctrl;
   logic signed [tam_pkg::SUM_BITS-1:0]    sum_x, sum_y, sum_z;
   logic signed [tam_pkg::SAMPLE_BITS-1:0] quot_x, quot_y, quot_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == tam_pkg::COUNT_BITS'(tam_pkg::WINDOW_LEN));
   // the output register is free when empty or emptied in this cycle
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign axis_ctrl.capture = accept;
   assign axis_ctrl.update  = (state_ff == ST_UPDATE);
   assign axis_ctrl.full    = full;

   assign div_ctrl.load = (state_ff == ST_LOAD);
   assign div_ctrl.step = (state_ff == ST_DIVIDE);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the held result once its beat is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // advance the slot with wraparound, climb the fill count to the window
            if (slot_ff == tam_pkg::SLOT_BITS'(tam_pkg::WINDOW_LEN - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == tam_pkg::DIV_STEP_BITS'(tam_pkg::SUM_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the means in the dividers until the output register frees up
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (out_load) begin
         mean_x_ff <= quot_x;
         mean_y_ff <= quot_y;
         mean_z_ff <= quot_z;
         warm_ff   <= full;
      end
   end

   tam_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (axis_ctrl),
      .sample (req_sample_x),
      .slot   (slot_ff),
      .sum    (sum_x)
   );

   tam_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (axis_ctrl),
      .sample (req_sample_y),
      .slot   (slot_ff),
      .sum    (sum_y)
   );

   tam_axis u_axis_z (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (axis_ctrl),
      .sample (req_sample_z),
      .slot   (slot_ff),
      .sum    (sum_z)
   );

   // the fill count is the divisor; it already includes the new sample
   tam_div u_div_x (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (sum_x),
      .divisor  (count_ff),
      .quotient (quot_x)
   );

   tam_div u_div_y (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (sum_y),
      .divisor  (count_ff),
      .quotient (quot_y)
   );

   tam_div u_div_z (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (sum_z),
      .divisor  (count_ff),
      .quotient (quot_z)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean_x    = mean_x_ff;
   assign rsp_mean_y    = mean_y_ff;
   assign rsp_mean_z    = mean_z_ff;
   assign rsp_warmed_up = warm_ff;

   // a result appears only out of the DONE state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("rsp_valid rose outside DONE");

   // the fill count never passes the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tam_pkg::COUNT_BITS'(tam_pkg::WINDOW_LEN))
      else $error("fill count beyond window");

   // the divisor is never zero while dividing
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (count_ff != '0))
      else $error("divide by zero count");

   // an accepted beat goes straight to the ring update
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_UPDATE))
      else $error("accepted beat did not reach UPDATE");

endmodule

// File: rtl/tam_ram.sv
module tam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tam_axis.sv
module tam_axis (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tam_pkg::axis_ctrl_type                 ctrl,
   input  logic signed [tam_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [tam_pkg::SLOT_BITS-1:0]          slot,
   output logic signed [tam_pkg::SUM_BITS-1:0]    sum
);

   logic signed [tam_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [tam_pkg::SUM_BITS-1:0]    sum_ff;
   logic signed [tam_pkg::SUM_BITS-1:0]    sum_in;
   logic [tam_pkg::SAMPLE_BITS-1:0]        ring_rd;
   logic [tam_pkg::SAMPLE_BITS-1:0]        oldest;
   logic [tam_pkg::SUM_BITS-1:0]           old_ext;
   logic [tam_pkg::SUM_BITS-1:0]           new_ext;

   tam_ram #(
      .WIDTH (tam_pkg::SAMPLE_BITS),
      .DEPTH (tam_pkg::WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctrl.update),
      .wr_addr (slot),
      .wr_data (sample_ff),
      .rd_addr (slot),
      .rd_data (ring_rd)
   );

   // entries past the fill point still read as zero
   assign oldest  = ctrl.full ? ring_rd : '0;
   assign old_ext = {{tam_pkg::EXT_BITS{oldest[tam_pkg::SAMPLE_BITS-1]}}, oldest};
   assign new_ext = {{tam_pkg::EXT_BITS{sample_ff[tam_pkg::SAMPLE_BITS-1]}}, sample_ff};

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.update) begin
         sum_in = signed'(sum_ff - old_ext + new_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         sample_ff <= sample;
      end
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: rtl/tam_div.sv
module tam_div (
   input  logic                                   clock,
   input  tam_pkg::div_ctrl_type                  ctrl,
   input  logic signed [tam_pkg::SUM_BITS-1:0]    dividend,
   input  logic [tam_pkg::COUNT_BITS-1:0]         divisor,
   output logic signed [tam_pkg::SAMPLE_BITS-1:0] quotient
);

   logic [tam_pkg::SUM_BITS-1:0]   dq_ff, dq_in;
   logic [tam_pkg::COUNT_BITS-1:0] rem_ff, rem_in;
   logic                           neg_ff, neg_in;
   logic [tam_pkg::COUNT_BITS:0]   rem_shift;
   logic [tam_pkg::COUNT_BITS:0]   rem_diff;
   logic [tam_pkg::SUM_BITS-1:0]   magnitude;

   // dividend bits leave at the top, quotient bits enter at the bottom
   assign rem_shift = {rem_ff, dq_ff[tam_pkg::SUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (ctrl.load) begin
         neg_in = dividend[tam_pkg::SUM_BITS-1];
         dq_in  = neg_in ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
      end else if (ctrl.step) begin
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = rem_diff[tam_pkg::COUNT_BITS-1:0];
            dq_in  = {dq_ff[tam_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[tam_pkg::COUNT_BITS-1:0];
            dq_in  = {dq_ff[tam_pkg::SUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // restore the sign: truncation toward zero
   assign magnitude = neg_ff ? (~dq_ff + 1'b1) : dq_ff;
   assign quotient  = signed'(magnitude[tam_pkg::SAMPLE_BITS-1:0]);

endmodule
